/* rtl/ppb_pkg.sv */
package ppb_pkg;

    localparam int NT_DEPTH    = 2048;
    localparam int PAL_DEPTH   = 32;
    localparam int NT_IDX_W    = $clog2(NT_DEPTH);
    localparam int PAL_IDX_W   = $clog2(PAL_DEPTH);
    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int MODE_W      = 2;

    // mirroring modes
    localparam logic [MODE_W-1:0] MODE_HORIZONTAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VERTICAL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SINGLE     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FOUR       = 2'd3;

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // address space boundaries
    localparam logic [ADDR_W-1:0] NT_SPACE_START  = 16'h2000;
    localparam logic [ADDR_W-1:0] PAL_SPACE_START = 16'h3F00;

    typedef enum logic [1:0] {
        TGT_PATTERN   = 2'd0,
        TGT_NAMETABLE = 2'd1,
        TGT_PALETTE   = 2'd2
    } target_t;

    typedef struct packed {
        target_t                target;
        logic [NT_IDX_W-1:0]    nt_index;
        logic [PAL_IDX_W-1:0]   pal_index;
    } access_t;

endpackage

/* rtl/ppb_decode.sv */
module ppb_decode (
    input  logic [ppb_pkg::MODE_W-1:0] mode,
    input  logic                       operation,
    input  logic [ppb_pkg::ADDR_W-1:0] address,
    output ppb_pkg::access_t           access
);
    import ppb_pkg::*;

    logic [PAL_IDX_W-1:0] pal_folded;

    always_comb
    begin
        // space select
        if (address < NT_SPACE_START)
        begin
            access.target = TGT_PATTERN;
        end
        else if (address < PAL_SPACE_START)
        begin
            access.target = TGT_NAMETABLE;
        end
        else
        begin
            access.target = TGT_PALETTE;
        end

        // nametable folding
        unique case (mode)
            MODE_HORIZONTAL: access.nt_index = {address[11], address[9:0]};
            MODE_SINGLE:     access.nt_index = {1'b0, address[9:0]};
            MODE_VERTICAL,
            MODE_FOUR:       access.nt_index = address[NT_IDX_W-1:0];
            default:         access.nt_index = address[NT_IDX_W-1:0];
        endcase

        // palette folding: sprite backdrop entries alias the background ones
        pal_folded = address[PAL_IDX_W-1:0];
        if (pal_folded[4] && (pal_folded[1:0] == 2'b00))
        begin
            pal_folded[4] = 1'b0;
        end
        // reads of the unused backdrop slots see the universal backdrop
        if ((operation == OP_READ) && (pal_folded[4] == 1'b0)
            && (pal_folded[1:0] == 2'b00) && (pal_folded[3:2] != 2'b00))
        begin
            pal_folded = '0;
        end
        access.pal_index = pal_folded;
    end

endmodule

/* rtl/ppu_nametable_palette_bus_top.sv */
// a result is valid in the cycle after its item is accepted
// throughput: one item per cycle while in_stall is low; each item uses at most one memory port
// reset: the folding mode clears to horizontal, then a clearing pass over every nametable index
// zeroes the nametable and palette memories; in_stall stays high for that pass
// configuration writes are taken at any time, including during the pass
module ppu_nametable_palette_bus_top (
    input  logic                       clk,
    input  logic                       rst_n,

    // configuration
    input  logic                       cfg_we,
    input  logic [ppb_pkg::MODE_W-1:0] cfg_wdata,

    // input item channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       operation,
    input  logic [ppb_pkg::ADDR_W-1:0] address,
    input  logic [ppb_pkg::DATA_W-1:0] write_data,

    // result item channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [ppb_pkg::DATA_W-1:0] read_data,
    output logic                       pattern_space
);
    import ppb_pkg::*;

    // one-hot sequencer: clearing pass, then normal operation
    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [NT_IDX_W-1:0]    clear_idx_reg;
    logic [NT_IDX_W-1:0]    clear_idx_next;

    logic [MODE_W-1:0]      mode_reg;

    access_t                access;
    logic                   in_accept;
    logic                   clearing;

    // memory port controls
    logic                   nt_we;
    logic                   nt_re;
    logic [NT_IDX_W-1:0]    nt_waddr;
    logic [DATA_W-1:0]      nt_wdata;
    logic                   pal_we;
    logic                   pal_re;
    logic [PAL_IDX_W-1:0]   pal_waddr;
    logic [DATA_W-1:0]      pal_wdata;

    logic [DATA_W-1:0]      nt_mem [NT_DEPTH];
    logic [DATA_W-1:0]      pal_mem [PAL_DEPTH];
    logic [DATA_W-1:0]      nt_rdata_reg;
    logic [DATA_W-1:0]      pal_rdata_reg;

    // result stage
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_read_reg;
    target_t                out_target_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_HORIZONTAL;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // address folding
    ppb_decode u_decode (
        .mode      (mode_reg),
        .operation (operation),
        .address   (address),
        .access    (access)
    );

    // clearing sequencer
    always_comb
    begin
        state_next     = state_reg;
        clear_idx_next = clear_idx_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clear_idx_next = clear_idx_reg + 1'b1;
                if (clear_idx_reg == NT_IDX_W'(NT_DEPTH - 1))
                begin
                    state_next     = ST_RUN;
                    clear_idx_next = '0;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next     = ST_CLEAR;
                clear_idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_idx_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_idx_reg <= clear_idx_next;
        end
    end

    assign clearing = (state_reg == ST_CLEAR);

    // take a new item unless clearing or a result is still waiting
    assign in_stall  = clearing || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;

    // memory port muxing: the clearing pass owns the write ports
    always_comb
    begin
        nt_we     = 1'b0;
        nt_re     = 1'b0;
        nt_waddr  = access.nt_index;
        nt_wdata  = write_data;
        pal_we    = 1'b0;
        pal_re    = 1'b0;
        pal_waddr = access.pal_index;
        pal_wdata = write_data;
        if (clearing)
        begin
            nt_we     = 1'b1;
            nt_waddr  = clear_idx_reg;
            nt_wdata  = '0;
            pal_we    = 1'b1;
            pal_waddr = clear_idx_reg[PAL_IDX_W-1:0];
            pal_wdata = '0;
        end
        else if (in_accept)
        begin
            case (access.target)
                TGT_NAMETABLE:
                begin
                    nt_we = (operation == OP_WRITE);
                    nt_re = (operation == OP_READ);
                end
                TGT_PALETTE:
                begin
                    pal_we = (operation == OP_WRITE);
                    pal_re = (operation == OP_READ);
                end
                default:
                begin
                    nt_we = 1'b0;
                end
            endcase
        end
    end

    // nametable memory, registered read; read data holds while stalled
    always_ff @(posedge clk)
    begin
        if (nt_we)
        begin
            nt_mem[nt_waddr] <= nt_wdata;
        end
        if (nt_re)
        begin
            nt_rdata_reg <= nt_mem[access.nt_index];
        end
    end

    // palette memory
    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[pal_waddr] <= pal_wdata;
        end
        if (pal_re)
        begin
            pal_rdata_reg <= pal_mem[access.pal_index];
        end
    end

    // result stage bookkeeping
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_read_reg   <= (operation == OP_READ);
            out_target_reg <= access.target;
        end
    end

    // writes give zero; pattern space reads give zero and raise the flag
    always_comb
    begin
        read_data = '0;
        if (out_read_reg)
        begin
            case (out_target_reg)
                TGT_NAMETABLE: read_data = nt_rdata_reg;
                TGT_PALETTE:   read_data = pal_rdata_reg;
                default:       read_data = '0;
            endcase
        end
    end

    assign pattern_space = out_read_reg && (out_target_reg == TGT_PATTERN);
    assign out_valid     = out_valid_reg;

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> in_stall)
        else $error("item accepted during clearing pass");

    a_write_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (operation == OP_WRITE))
            |=> (out_valid && (read_data == '0) && !pattern_space))
        else $error("write produced a nonzero result");

    a_pattern_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pattern_space) |-> (read_data == '0))
        else $error("pattern space read returned data");

    a_clear_done_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (clear_idx_reg == '0))
        else $error("clear index moved after clearing pass");
`endif

endmodule
